>>> rtl/chb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chb_pkg
// Types, codes and helpers shared by the chunked body decoder modules.
// ----------------------------------------------------------------------------
package chb_pkg;

    localparam int SIZE_BITS      = 63;
    localparam int LINE_CNT_BITS  = 17;
    localparam logic [15:0] MAX_LINE_LEN_RESET = 16'd16384;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_DATA    = 3'd1,
        PH_TERM    = 3'd2,
        PH_TRAILER = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        PART_DIGITS = 2'd0,
        PART_SPACES = 2'd1,
        PART_EXT    = 2'd2
    } part_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_BAD_SIZE = 3'd1,
        ERR_NO_CRLF  = 3'd2,
        ERR_EMPTY    = 3'd3,
        ERR_TOO_LONG = 3'd4,
        ERR_OVERFLOW = 3'd5
    } err_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       buffer_end;
    } item_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0]     size_accum;
        part_t                    part;
        logic [LINE_CNT_BITS-1:0] count;
        logic                     digit_seen;
        logic                     bad_seen;
        logic                     cr_pending;
    } line_st_t;

    typedef struct packed {
        line_st_t line;
        err_t     err;
    } ctx_t;

    localparam logic [LINE_CNT_BITS-1:0] LINE_CNT_MAX = {LINE_CNT_BITS{1'b1}};

    // {is_hex, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    function automatic ctx_t add_content(input ctx_t x, input phase_t ph,
                                         input logic [7:0] c, input logic [15:0] maxl);
        ctx_t       r;
        logic [4:0] hv;
        r  = x;
        hv = hex_value(c);
        if (r.line.count != LINE_CNT_MAX)
            r.line.count = r.line.count + 1'b1;
        if (r.line.count > {1'b0, maxl}) begin
            r.err = ERR_TOO_LONG;
        end else if (ph == PH_SIZE) begin
            case (r.line.part)
                PART_DIGITS:
                begin
                    if (hv[4]) begin
                        if (!r.line.bad_seen) begin
                            if (r.line.size_accum[SIZE_BITS-1 -: 4] != 4'd0) begin
                                r.err = ERR_OVERFLOW;
                            end else begin
                                r.line.size_accum = {r.line.size_accum[SIZE_BITS-5:0],
                                                     hv[3:0]};
                                r.line.digit_seen = 1'b1;
                            end
                        end
                    end else if (c == CH_SPACE) begin
                        if (r.line.digit_seen)
                            r.line.part = PART_SPACES;
                        else
                            r.line.bad_seen = 1'b1;
                    end else if (c == CH_SEMI) begin
                        r.line.part = PART_EXT;
                    end else begin
                        r.line.bad_seen = 1'b1;
                    end
                end
                PART_SPACES:
                begin
                    if (c == CH_SEMI)
                        r.line.part = PART_EXT;
                    else if (c != CH_SPACE)
                        r.line.bad_seen = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/chb_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chb_in_reg
// Input register: captures one byte transfer and holds it until the
// decode stage takes it.
// ----------------------------------------------------------------------------
module chb_in_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    in_byte,
    input  wire logic          buffer_end,
    output logic               item_valid,
    output chb_pkg::item_t     item,
    input  wire logic          item_take
);
    import chb_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign in_stall   = valid_reg && !item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.in_byte    <= in_byte;
            item_reg.buffer_end <= buffer_end;
        end
    end

endmodule
`default_nettype wire

>>> rtl/chb_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chb_core
// Decoder state, one-byte decode step and result register.
// ----------------------------------------------------------------------------
module chb_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [15:0]   cfg_wdata,
    input  wire logic          item_valid,
    input  wire chb_pkg::item_t item,
    output logic               item_take,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         data_byte,
    output logic               data_valid,
    output logic               body_done,
    output logic [2:0]         error_code,
    output logic [15:0]        block_data_count,
    output logic [31:0]        extra_byte_count
);
    import chb_pkg::*;

    logic [15:0]          max_len_reg;
    phase_t               phase_reg, phase_next;
    logic [SIZE_BITS-1:0] left_reg, left_next;
    ctx_t                 ctx_reg, ctx_next;
    logic [15:0]          blk_reg, blk_next, blk_out;
    logic [31:0]          extra_reg, extra_next;
    logic                 dv_next;

    logic                 out_valid_reg;
    logic [7:0]           data_byte_reg;
    logic                 data_valid_reg;
    logic                 body_done_reg;
    logic [2:0]           error_code_reg;
    logic [15:0]          blk_out_reg;
    logic [31:0]          extra_out_reg;

    logic                 advance;

    assign advance   = !out_valid_reg || !out_stall;
    assign item_take = item_valid && advance;

    always_comb
    begin
        ctx_t                 c;
        logic [SIZE_BITS-1:0] left;
        c          = ctx_reg;
        left       = left_reg;
        phase_next = phase_reg;
        blk_out    = blk_reg;
        extra_next = extra_reg;
        dv_next    = 1'b0;
        if (ctx_reg.err == ERR_NONE)
        begin
            if (phase_reg == PH_DATA)
            begin
                dv_next = 1'b1;
                if (blk_reg != 16'hFFFF)
                    blk_out = blk_reg + 16'd1;
                if (left != '0)
                    left = left - 1'b1;
                if (left == '0)
                    phase_next = PH_TERM;
            end
            else if (phase_reg == PH_DONE)
            begin
                if (extra_reg != 32'hFFFF_FFFF)
                    extra_next = extra_reg + 32'd1;
            end
            else if (item.in_byte == CH_LF)
            begin
                case (phase_reg)
                    PH_SIZE:
                    begin
                        if (c.line.count == '0)
                            c.err = ERR_EMPTY;
                        else if (c.line.bad_seen || !c.line.digit_seen)
                            c.err = ERR_BAD_SIZE;
                        else if (c.line.size_accum == '0)
                            phase_next = PH_TRAILER;
                        else
                        begin
                            left       = c.line.size_accum;
                            phase_next = PH_DATA;
                        end
                    end
                    PH_TERM:
                    begin
                        if (c.line.count != '0)
                            c.err = ERR_NO_CRLF;
                        else
                            phase_next = PH_SIZE;
                    end
                    PH_TRAILER:
                    begin
                        if (c.line.count == '0)
                            phase_next = PH_DONE;
                    end
                    default:
                    begin
                    end
                endcase
                c.line = '{size_accum: '0, part: PART_DIGITS, count: '0,
                           digit_seen: 1'b0, bad_seen: 1'b0, cr_pending: 1'b0};
            end
            else
            begin
                if (c.line.cr_pending)
                begin
                    c.line.cr_pending = 1'b0;
                    c = add_content(c, phase_reg, CH_CR, max_len_reg);
                end
                if (c.err == ERR_NONE)
                begin
                    if (item.in_byte == CH_CR)
                        c.line.cr_pending = 1'b1;
                    else
                        c = add_content(c, phase_reg, item.in_byte, max_len_reg);
                end
            end
        end
        ctx_next  = c;
        left_next = left;
        blk_next  = item.buffer_end ? 16'd0 : blk_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LINE_LEN_RESET;
            phase_reg   <= PH_SIZE;
            left_reg    <= '0;
            ctx_reg     <= '{line: '{size_accum: '0, part: PART_DIGITS, count: '0,
                                     digit_seen: 1'b0, bad_seen: 1'b0,
                                     cr_pending: 1'b0},
                             err: ERR_NONE};
            blk_reg     <= '0;
            extra_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                max_len_reg <= cfg_wdata;
            if (item_take)
            begin
                phase_reg <= phase_next;
                left_reg  <= left_next;
                ctx_reg   <= ctx_next;
                blk_reg   <= blk_next;
                extra_reg <= extra_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            data_byte_reg  <= dv_next ? item.in_byte : 8'd0;
            data_valid_reg <= dv_next;
            body_done_reg  <= (phase_next == PH_DONE);
            error_code_reg <= ctx_next.err;
            blk_out_reg    <= blk_out;
            extra_out_reg  <= extra_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign data_byte        = data_byte_reg;
    assign data_valid       = data_valid_reg;
    assign body_done        = body_done_reg;
    assign error_code       = error_code_reg;
    assign block_data_count = blk_out_reg;
    assign extra_byte_count = extra_out_reg;

endmodule
`default_nettype wire

>>> rtl/http_chunked_body_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Chunked HTTP body decoder, one byte per transfer.
//
// Input channel in_valid/in_stall carries in_byte and buffer_end. Output
// channel out_valid/out_stall carries one result per input byte: the
// payload byte with data_valid, body_done, sticky error_code and the
// block and post-body counters.
// A byte taken at the input sits in the input register; the combinational
// decode step between the two registers computes its result, which is loaded
// into the output register once that register is free or being taken, and
// out_valid rises. One byte per cycle is sustained while out_stall is low.
// When the receiver stalls, the output register holds its result and the
// input register takes one more byte; in_stall then rises until the
// output is taken.
// Reset clears both registers' valid flags and decoder state; the line length
// limit returns to 16384. Users write it by cfg_we only while idle; unchecked.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        buffer_end,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       data_byte,
    output logic             data_valid,
    output logic             body_done,
    output logic [2:0]       error_code,
    output logic [15:0]      block_data_count,
    output logic [31:0]      extra_byte_count
);
    import chb_pkg::*;

    logic  item_valid;
    item_t item;
    logic  item_take;

    chb_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .buffer_end (buffer_end),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    chb_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .item_valid       (item_valid),
        .item             (item),
        .item_take        (item_take),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .data_byte        (data_byte),
        .data_valid       (data_valid),
        .body_done        (body_done),
        .error_code       (error_code),
        .block_data_count (block_data_count),
        .extra_byte_count (extra_byte_count)
    );

    a_data_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data_valid |-> error_code == ERR_NONE)
        else $error("payload transfer with error set");

    a_done_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(body_done && data_valid))
        else $error("payload after body end");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && error_code != ERR_NONE
        |=> !out_valid || error_code == $past(error_code))
        else $error("error code changed");

endmodule
`default_nettype wire
